>>> sv/kahan_compensated_sum_core_macros.svh
// assertion macros for the kahan summation core
`ifndef KAHAN_COMPENSATED_SUM_CORE_MACROS_SVH
`define KAHAN_COMPENSATED_SUM_CORE_MACROS_SVH
`define KCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define KCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> sv/kcs_pkg.sv
// types and constants for the kahan summation core
`default_nettype none
package kcs_pkg;
   localparam int unsigned FpWidth = 32;
   typedef logic [FpWidth-1:0] fp_type;
   localparam fp_type QnanBits = 32'h7fc0_0000;
   localparam fp_type PosZero  = 32'h0000_0000;
   localparam fp_type SignBit  = 32'h8000_0000;
endpackage
`default_nettype wire

>>> sv/kcs_fadd.sv
// combinational binary32 adder, round to nearest even
`default_nettype none
module kcs_fadd (
   input  kcs_pkg::fp_type a,
   input  kcs_pkg::fp_type b,
   output kcs_pkg::fp_type s
);
   import kcs_pkg::*;
   logic       sa, sb, sx, sy, sgn;
   logic [7:0] ea, eb, fxe, fye;
   logic [22:0] fa, fb;
   logic [26:0] ma, mb, mx, my, mys;
   logic [7:0]  d;
   logic [27:0] r;
   logic [26:0] rn;
   logic [4:0]  lz, sh;
   logic [9:0]  e;
   logic [24:0] rr;
   logic [2:0]  low;
   logic        a_nan, b_nan, a_inf, b_inf, a_z, b_z, swap;

   always_comb begin
      sa = a[31]; sb = b[31];
      ea = a[30:23]; eb = b[30:23];
      fa = a[22:0]; fb = b[22:0];
      a_nan = (ea == 8'hff) && (fa != '0);
      b_nan = (eb == 8'hff) && (fb != '0);
      a_inf = (ea == 8'hff) && (fa == '0);
      b_inf = (eb == 8'hff) && (fb == '0);
      a_z = (a[30:0] == '0);
      b_z = (b[30:0] == '0);
      ma = {(ea != '0), fa, 3'b000};
      mb = {(eb != '0), fb, 3'b000};
      fxe = (ea == '0) ? 8'd1 : ea;
      fye = (eb == '0) ? 8'd1 : eb;
      swap = (fye > fxe) || ((fye == fxe) && (mb > ma));
      mx = swap ? mb : ma;
      my = swap ? ma : mb;
      sx = swap ? sb : sa;
      sy = swap ? sa : sb;
      if (swap) begin
         fxe = fye;
         fye = (ea == '0) ? 8'd1 : ea;
      end
      d = fxe - fye;
      if (d >= 8'd27) mys = 27'd1;
      else mys = (my >> d) | {26'd0, ((my & ((27'd1 << d) - 27'd1)) != '0)};
      sgn = sx;
      e = {2'b00, fxe};
      r = '0;
      rn = '0;
      lz = '0;
      sh = '0;
      if (sx == sy) begin
         r = {1'b0, mx} + {1'b0, mys};
         if (r[27]) begin
            rn = r[27:1] | {26'd0, r[0]};
            e = e + 10'd1;
         end else begin
            rn = r[26:0];
         end
      end else begin
         rn = mx - mys;
         for (int i = 26; i >= 0; i--) begin
            if (rn[i] && lz == '0 && i != 0) lz = 5'(26 - i);
         end
         if (rn[26]) lz = '0;
         if ({2'b00, fxe} - 10'd1 < {5'd0, lz}) sh = 5'(fxe - 8'd1);
         else sh = lz;
         rn = rn << sh;
         e = e - {5'd0, sh};
      end
      low = rn[2:0];
      rr = {1'b0, rn[26:3]};
      if (low > 3'd4 || (low == 3'd4 && rr[0])) rr = rr + 25'd1;
      if (rr[24]) begin
         rr = rr >> 1;
         e = e + 10'd1;
      end
      if (a_nan || b_nan || (a_inf && b_inf && sa != sb)) s = QnanBits;
      else if (a_inf) s = a;
      else if (b_inf) s = b;
      else if (a_z && b_z) s = {sa & sb, 31'd0};
      else if (a_z) s = b;
      else if (b_z) s = a;
      else if (sx != sy && mx == mys) s = PosZero;
      else if (e >= 10'd255) s = {sgn, 8'hff, 23'd0};
      else if (!rr[23]) s = {sgn, 8'd0, rr[22:0]};
      else s = {sgn, e[7:0], rr[22:0]};
   end
endmodule
`default_nettype wire

>>> sv/kahan_compensated_sum_core.sv
// Kahan compensated summation core for binary32 values. One value is
// taken per cycle unless stalled; the four adds of one step form a
// combinational chain from the input register through the running sum
// and compensation registers. For a last value the result goes to an
// output register and is held; sum and compensation clear after a last
// value. The input stalls only while a last value sits in the input
// register and the previous result is still held by rsp_stall.
`default_nettype none
`include "kahan_compensated_sum_core_macros.svh"
module kahan_compensated_sum_core (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  kcs_pkg::fp_type req_value_bits,
   input  logic           req_last_value,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output kcs_pkg::fp_type rsp_sum_bits
);
   import kcs_pkg::*;
   logic   in_vld_ff, in_last_ff, out_vld_ff;
   fp_type in_val_ff, sum_ff, comp_ff, out_ff;
   fp_type y, t, d1, c_new;
   logic   adv;
   logic   out_vld_in;

   kcs_fadd u_y (.a(in_val_ff), .b(comp_ff ^ SignBit), .s(y));
   kcs_fadd u_t (.a(sum_ff), .b(y), .s(t));
   kcs_fadd u_d (.a(t), .b(sum_ff ^ SignBit), .s(d1));
   kcs_fadd u_c (.a(d1), .b(y ^ SignBit), .s(c_new));

   // stage stalls only when a last item cannot leave
   assign adv = !(in_vld_ff && in_last_ff && out_vld_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = out_vld_ff;
   assign rsp_sum_bits = out_ff;
   assign out_vld_in = (adv && in_vld_ff && in_last_ff) || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         sum_ff <= PosZero;
         comp_ff <= PosZero;
      end else begin
         out_vld_ff <= out_vld_in;
         if (adv) begin
            in_vld_ff <= req_valid;
            if (in_vld_ff) begin
               if (in_last_ff) begin
                  sum_ff <= PosZero;
                  comp_ff <= PosZero;
               end else begin
                  sum_ff <= t;
                  comp_ff <= c_new;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_val_ff <= req_value_bits;
         in_last_ff <= req_last_value;
         if (in_vld_ff && in_last_ff) out_ff <= t;
      end
   end

   `KCS_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sum_bits), "result dropped while stalled")
   `KCS_ASSERT_NEXT(a_clear, clock, reset, in_vld_ff && in_last_ff && adv, sum_ff == PosZero && comp_ff == PosZero, "state not cleared")
   `KCS_ASSERT_IMPL(a_stall, clock, reset, req_stall, out_vld_ff && in_vld_ff, "stall without pending result")
endmodule
`default_nettype wire
